@@ src/iraf_pkg.sv @@
`timescale 1ns / 1ps

package iraf_pkg;

  localparam int unsigned MAX_BUFFER = 64;
  localparam int unsigned MIN_BUFFER = 4;
  localparam int unsigned MAX_DIGITS = 32;

  localparam int unsigned LEN_W   = 7;   // buffer_len field
  localparam int unsigned PAD_W   = 6;   // pad_width field
  localparam int unsigned CNT_W   = 6;   // digit count and byte cursor, 0..63
  localparam int unsigned DIG_IDX_W = 5; // index into the 32-entry digit store

  // radix_sel codes
  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  // ASCII codes
  localparam logic [7:0] ASC_NUL   = 8'h00;
  localparam logic [7:0] ASC_MINUS = 8'h2d;
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_A_LC  = 8'h61;
  localparam logic [7:0] ASC_B_LC  = 8'h62;
  localparam logic [7:0] ASC_O_LC  = 8'h6f;
  localparam logic [7:0] ASC_X_LC  = 8'h78;

  // ceil(2^35 / 10): floor(x * RECIP10 / 2^35) == floor(x / 10) for any 32-bit x
  localparam logic [31:0] RECIP10 = 32'hcccc_cccd;
  localparam int unsigned RECIP10_SHIFT = 35;

  // which byte the datapath loads into the output register
  typedef enum logic [2:0] {
    CH_SIGN   = 3'd0,
    CH_ZERO   = 3'd1,
    CH_LETTER = 3'd2,
    CH_DIGIT  = 3'd3,
    CH_NUL    = 3'd4,
    CH_ERR    = 3'd5
  } char_sel_t;

  typedef struct packed {
    logic      idle;
    logic      load;
    logic      mul;
    logic      dig;
    logic      emit;
    char_sel_t char_sel;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_err;
    logic in_dec;
    logic neg;
    logic dec;
    logic dig_done;
    logic pos_zero;
    logic pos_last;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] c;
    if (d >= 4'd10) begin
      c = ASC_A_LC + {4'd0, d} - 8'd10;
    end else begin
      c = ASC_ZERO + {4'd0, d};
    end
    return c;
  endfunction

endpackage

@@ src/iraf_if.sv @@
`timescale 1ns / 1ps

interface iraf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         radix_sel;
  logic [6:0]         buffer_len;
  logic [5:0]         pad_width;

  modport source (output valid, value, radix_sel, buffer_len, pad_width, input ready);
  modport sink   (input valid, value, radix_sel, buffer_len, pad_width, output ready);
endinterface

interface iraf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       status;

  modport source (output valid, out_char, last, status, input ready);
  modport sink   (input valid, out_char, last, status, output ready);
endinterface

@@ src/iraf_dp.sv @@
`timescale 1ns / 1ps

module iraf_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  iraf_pkg::cmd_t  cmd,
  output iraf_pkg::stat_t stat,
  iraf_in_if.sink       in_chan,
  iraf_out_if.source    out_chan
);
  import iraf_pkg::*;

  // request registers
  logic [31:0]      mag_r;
  logic             neg_r;
  logic [1:0]       sel_r;
  logic [CNT_W-1:0] room_r;
  logic [PAD_W-1:0] pad_r;
  logic [CNT_W-1:0] ndig_r;
  logic [CNT_W-1:0] pos_r;
  logic [63:0]      prod_r;
  logic [3:0]       digs_r [MAX_DIGITS];

  // output register
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       last_r;
  logic       status_r;

  // load-side decode
  logic [31:0]      in_bits;
  logic [LEN_W-1:0] blen_c;
  logic [LEN_W-1:0] room_full;
  logic             in_neg;
  logic             in_dec;

  // digit step
  logic [28:0]      q10;
  logic [31:0]      q10_x;
  logic [31:0]      r10_full;
  logic [3:0]       dval;
  logic [31:0]      mag_nxt;
  logic [CNT_W-1:0] ndig_inc;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] n_nxt;

  // emission
  logic [CNT_W-1:0] pos_m1;
  logic [7:0]       dig_char;
  logic [7:0]       letter;
  logic [7:0]       char_nxt;
  logic             last_nxt;
  logic             status_nxt;

  assign in_bits = in_chan.value;
  assign in_neg  = in_bits[31];
  assign in_dec  = (in_chan.radix_sel == RADIX_DEC);
  assign blen_c  = (in_chan.buffer_len > LEN_W'(MAX_BUFFER)) ? LEN_W'(MAX_BUFFER)
                                                              : in_chan.buffer_len;
  // bytes left for digits once sign, prefix and NUL are placed
  assign room_full = blen_c - LEN_W'(1) - LEN_W'(in_neg) - (in_dec ? LEN_W'(0) : LEN_W'(2));

  // decimal digit from the registered reciprocal product
  assign q10      = prod_r[63:RECIP10_SHIFT];
  assign q10_x    = {3'd0, q10};
  assign r10_full = mag_r - (q10_x << 3) - (q10_x << 1);

  always_comb begin
    case (sel_r)
      RADIX_BIN: begin
        dval    = {3'd0, mag_r[0]};
        mag_nxt = mag_r >> 1;
      end
      RADIX_OCT: begin
        dval    = {1'b0, mag_r[2:0]};
        mag_nxt = mag_r >> 3;
      end
      RADIX_DEC: begin
        dval    = r10_full[3:0];
        mag_nxt = q10_x;
      end
      default: begin
        dval    = mag_r[3:0];
        mag_nxt = mag_r >> 4;
      end
    endcase
  end

  assign ndig_inc = ndig_r + CNT_W'(1);
  assign total    = (ndig_inc > pad_r) ? ndig_inc : pad_r;
  assign n_nxt    = (total < room_r) ? total : room_r;

  assign pos_m1   = pos_r - CNT_W'(1);
  assign dig_char = (pos_m1 < ndig_r) ? digit_ascii(digs_r[pos_m1[DIG_IDX_W-1:0]]) : ASC_ZERO;

  always_comb begin
    case (sel_r)
      RADIX_BIN: letter = ASC_B_LC;
      RADIX_OCT: letter = ASC_O_LC;
      RADIX_HEX: letter = ASC_X_LC;
      default:   letter = ASC_NUL;
    endcase
  end

  always_comb begin
    char_nxt   = ASC_NUL;
    last_nxt   = 1'b0;
    status_nxt = 1'b0;
    case (cmd.char_sel)
      CH_SIGN:   char_nxt = ASC_MINUS;
      CH_ZERO:   char_nxt = ASC_ZERO;
      CH_LETTER: char_nxt = letter;
      CH_DIGIT:  char_nxt = dig_char;
      CH_NUL:    last_nxt = 1'b1;
      CH_ERR: begin
        last_nxt   = 1'b1;
        status_nxt = 1'b1;
      end
      default:   char_nxt = ASC_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r  <= in_neg ? (32'd0 - in_bits) : in_bits;
      neg_r  <= in_neg;
      sel_r  <= in_chan.radix_sel;
      room_r <= room_full[CNT_W-1:0];
      pad_r  <= in_chan.pad_width;
      ndig_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= 64'(mag_r) * 64'(RECIP10);
    end
    if (cmd.dig) begin
      digs_r[ndig_r[DIG_IDX_W-1:0]] <= dval;
      ndig_r <= ndig_inc;
      mag_r  <= mag_nxt;
      pos_r  <= n_nxt;
    end
    if (cmd.emit && (cmd.char_sel == CH_DIGIT)) begin
      pos_r <= pos_m1;
    end
    if (cmd.emit) begin
      out_char_r <= char_nxt;
      last_r     <= last_nxt;
      status_r   <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_chan.ready   = cmd.idle;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.out_char = out_char_r;
  assign out_chan.last   = last_r;
  assign out_chan.status = status_r;

  assign stat.in_valid = in_chan.valid;
  assign stat.in_err   = (blen_c < LEN_W'(MIN_BUFFER));
  assign stat.in_dec   = in_dec;
  assign stat.neg      = neg_r;
  assign stat.dec      = (sel_r == RADIX_DEC);
  assign stat.dig_done = (mag_nxt == 32'd0) || (ndig_r == CNT_W'(MAX_DIGITS - 1));
  assign stat.pos_zero = (pos_r == '0);
  assign stat.pos_last = (pos_r == CNT_W'(1));
  assign stat.out_free = !out_valid_r || out_chan.ready;

endmodule

@@ src/iraf_ctrl.sv @@
`timescale 1ns / 1ps

module iraf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  iraf_pkg::stat_t stat,
  output iraf_pkg::cmd_t  cmd
);
  import iraf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b0_0000_0001,
    S_MUL    = 9'b0_0000_0010,
    S_DIG    = 9'b0_0000_0100,
    S_SIGN   = 9'b0_0000_1000,
    S_ZERO   = 9'b0_0001_0000,
    S_LETTER = 9'b0_0010_0000,
    S_DIGIT  = 9'b0_0100_0000,
    S_NUL    = 9'b0_1000_0000,
    S_ERR    = 9'b1_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.char_sel = CH_NUL;
    cmd.idle     = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (stat.in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_err) begin
            state_nxt = S_ERR;
          end else if (stat.in_dec) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DIG;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIG;
      end
      S_DIG: begin
        cmd.dig = 1'b1;
        if (stat.dig_done) begin
          if (stat.neg) begin
            state_nxt = S_SIGN;
          end else if (!stat.dec) begin
            state_nxt = S_ZERO;
          end else begin
            state_nxt = S_DIGIT;
          end
        end else begin
          state_nxt = stat.dec ? S_MUL : S_DIG;
        end
      end
      S_SIGN: begin
        cmd.char_sel = CH_SIGN;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.dec ? S_DIGIT : S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.char_sel = CH_ZERO;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LETTER;
        end
      end
      S_LETTER: begin
        cmd.char_sel = CH_LETTER;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.char_sel = CH_DIGIT;
        if (stat.pos_zero) begin
          state_nxt = S_NUL;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.pos_last) begin
            state_nxt = S_NUL;
          end
        end
      end
      S_NUL: begin
        cmd.char_sel = CH_NUL;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.char_sel = CH_ERR;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // short buffer goes straight to the error byte
  a_err_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && stat.in_err) |=> (state_r == S_ERR))
    else $error("short buffer request did not take the error path");

  // never overwrite a byte the receiver has not taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("output register loaded while still occupied");

  // product is always consumed in the cycle after it is formed
  a_mul_dig: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_DIG))
    else $error("reciprocal product not followed by a digit step");

  // terminator closes the request
  a_nul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.char_sel == CH_NUL)) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after the terminator");

endmodule

@@ src/integer_to_ascii_radix_formatter_core.sv @@
`timescale 1ns / 1ps

// Integer to ASCII formatter, base 2, 8, 10 or 16.
// in_chan: one request = signed value, radix_sel, buffer_len, pad_width.
//   Accepted when valid and ready are high at a clock edge; ready is high only
//   while no request is in conversion, so one request is worked at a time.
// out_chan: one byte per transfer: optional '-', prefix 0b/0o/0x (not for
//   decimal), digits (lower-case hex, zero padded), then NUL with last set.
//   buffer_len below 4 gives a single NUL byte with last and status set.
// Sequence: after the accept, digit extraction runs one digit step per digit
//   for the power-of-two radices (up to 32 digits); decimal takes a
//   reciprocal multiply then a remainder step per digit. Bytes then leave
//   at one per cycle while the receiver is ready, up to 64; when no digit
//   fits, the digit state passes on to the NUL without giving a byte.
// The output register frees the controller: the next request is taken while
//   the final NUL still waits. A stalled receiver holds the byte and the
//   controller simply waits; nothing is dropped.
// Reset (rst_n low, synchronous) returns the controller to idle and empties
//   the output register. No clearing pass is needed.

module integer_to_ascii_radix_formatter_core (
  input  logic       clk,
  input  logic       rst_n,
  iraf_in_if.sink    in_chan,
  iraf_out_if.source out_chan
);
  import iraf_pkg::*;

  cmd_t  cmd;   // controller to datapath
  stat_t stat;  // datapath to controller

  // sequencing: accept, digit loop, byte emission
  iraf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // magnitude, divider, digit store, byte select and output register
  iraf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

@@ tb/sv/integer_to_ascii_radix_formatter_core_tb.sv @@
`timescale 1ns / 1ps

module integer_to_ascii_radix_formatter_core_tb;
  import iraf_pkg::*;

  // Longest quiet stretch in a correct run: a sender gap, the digit loop, and a
  // receiver stall run at its lowest ready rate. A stretch longer than
  // IDLE_LIMIT with no request or byte taken means a hang.
  localparam int unsigned IDLE_LIMIT   = 4000;
  // Quiet time after the last expected byte, to catch stray extra bytes.
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned RANDOM_REQS  = 410;

  typedef struct packed {
    logic signed [31:0]    value;
    logic [1:0]            radix_sel;
    logic [LEN_W-1:0]      buffer_len;
    logic [PAD_W-1:0]      pad_width;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       status;
  } fmt_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  iraf_in_if  in_chan ();
  iraf_out_if out_chan ();

  integer_to_ascii_radix_formatter_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and bytes the formatter still owes us.
  fmt_req_t  pending_reqs[$];
  fmt_byte_t expected_bytes[$];

  int errors         = 0;
  int reqs_taken     = 0;
  int bytes_checked  = 0;
  int short_buf_reqs = 0;
  int radix_count[4] = '{0, 0, 0, 0};
  int burst_left     = 4;
  int gap_left       = 0;
  int idle_cycles    = 0;
  int ready_pct      = 100;
  int stall_phase    = 0;

  function automatic void push_byte(input logic [7:0] ch, input logic last,
                                    input logic status);
    fmt_byte_t b;
    b.ch     = ch;
    b.last   = last;
    b.status = status;
    expected_bytes.push_back(b);
  endfunction

  // Builds the byte string that one request must produce: optional sign, radix
  // prefix (none for decimal), zero-padded digits (least significant kept when
  // short of room), then the terminating NUL; too short a buffer gives a lone NUL.
  function automatic void predict_string(input fmt_req_t r);
    logic [31:0] mag;
    logic [7:0]  digs [MAX_DIGITS];
    logic [4:0]  base;
    logic [7:0]  letter;
    logic [3:0]  d;
    logic        neg;
    int          len, ndig, room, total, n, pos;

    len = r.buffer_len;
    if (len > MAX_BUFFER) len = MAX_BUFFER;
    if (len < MIN_BUFFER) begin
      // buffer too small: lone NUL flagged with status
      push_byte(ASC_NUL, 1'b1, 1'b1);
      short_buf_reqs++;
      return;
    end

    case (r.radix_sel)
      RADIX_BIN: begin base = 5'd2;  letter = ASC_B_LC; end
      RADIX_OCT: begin base = 5'd8;  letter = ASC_O_LC; end
      RADIX_DEC: begin base = 5'd10; letter = ASC_NUL;  end
      default:   begin base = 5'd16; letter = ASC_X_LC; end
    endcase

    // most negative value wraps to magnitude 2^31 as an unsigned word
    neg = r.value[31];
    mag = neg ? (32'd0 - r.value) : r.value;

    // digits gathered least significant first; zero gives one '0'
    ndig = 0;
    do begin
      d = 4'(mag % base);
      digs[ndig] = (d >= 4'd10) ? (ASC_A_LC + 8'(d) - 8'd10) : (ASC_ZERO + 8'(d));
      ndig++;
      mag = mag / base;
    end while (mag != 0 && ndig < MAX_DIGITS);

    room = len - 1;
    if (neg) begin
      push_byte(ASC_MINUS, 1'b0, 1'b0);
      room--;
    end
    if (letter != ASC_NUL) begin
      push_byte(ASC_ZERO, 1'b0, 1'b0);
      push_byte(letter, 1'b0, 1'b0);
      room -= 2;
    end

    total = (ndig > r.pad_width) ? ndig : r.pad_width;
    n = (total < room) ? total : room;
    for (int j = n; j > 0; j--) begin
      pos = j - 1;
      push_byte((pos < ndig) ? digs[pos] : ASC_ZERO, 1'b0, 1'b0);
    end

    push_byte(ASC_NUL, 1'b1, 1'b0);
  endfunction

  function automatic void add_req(input logic [31:0] value, input logic [1:0] radix_sel,
                                  input int buffer_len, input int pad_width);
    fmt_req_t r;
    r.value      = value;
    r.radix_sel  = radix_sel;
    r.buffer_len = LEN_W'(buffer_len);
    r.pad_width  = PAD_W'(pad_width);
    pending_reqs.push_back(r);
  endfunction

  // Sender: bursts of requests, then a random gap. A request on offer is held
  // until taken; the next one goes out at the same edge or after the gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_string(pending_reqs[0]);
        radix_count[pending_reqs[0].radix_sel]++;
        reqs_taken++;
        pending_reqs.delete(0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long burst, and now and then no gap after the burst
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 6);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_chan.valid      <= 1'b1;
          in_chan.value      <= pending_reqs[0].value;
          in_chan.radix_sel  <= pending_reqs[0].radix_sel;
          in_chan.buffer_len <= pending_reqs[0].buffer_len;
          in_chan.pad_width  <= pending_reqs[0].pad_width;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each byte against the oldest expectation. Ready follows
  // a rate that is re-chosen each time stall_phase wraps, from always-ready to heavy stall.
  always @(posedge clk) begin : byte_monitor
    fmt_byte_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: out_char %h last %b status %b",
                 out_chan.out_char, out_chan.last, out_chan.status);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_chan.out_char !== want.ch) begin
            $error("out_char mismatch: expected %h, actual %h", want.ch, out_chan.out_char);
            errors++;
          end
          if (out_chan.last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_chan.last);
            errors++;
          end
          if (out_chan.status !== want.status) begin
            $error("status mismatch: expected %b, actual %b", want.status, out_chan.status);
            errors++;
          end
        end
      end
      stall_phase++;
      if (stall_phase == 256) begin
        stall_phase = 0;
        case ($urandom_range(0, 4))
          0, 1:    ready_pct = 100;
          2:       ready_pct = 85;
          3:       ready_pct = 50;
          default: ready_pct = 20;
        endcase
      end
      out_chan.ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Watchdog on handshake activity.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    fmt_req_t r;

    in_chan.valid      = 1'b0;
    in_chan.value      = '0;
    in_chan.radix_sel  = RADIX_BIN;
    in_chan.buffer_len = '0;
    in_chan.pad_width  = '0;
    out_chan.ready     = 1'b0;

    // directed: zero, extremes, every radix, short and oversized buffers
    add_req(32'd0,        RADIX_DEC, 16,  0);
    add_req(32'd0,        RADIX_BIN, 16,  0);
    add_req(32'h8000_0000, RADIX_BIN, 64,  0);   // most negative, 32 binary digits
    add_req(32'h8000_0000, RADIX_DEC, 127, 0);   // oversized buffer
    add_req(32'h7fff_ffff, RADIX_OCT, 64,  63);
    add_req(32'h7fff_ffff, RADIX_HEX, 64,  0);
    add_req(32'hffff_ffff, RADIX_HEX, 4,   0);   // sign and prefix fill the buffer
    add_req(32'd5,        RADIX_DEC, 0,   0);    // buffer too small
    add_req(32'd5,        RADIX_HEX, 1,   0);
    add_req(32'd5,        RADIX_OCT, 2,   0);
    add_req(32'hffff_fffb, RADIX_BIN, 3,   63);
    add_req(32'd123,      RADIX_DEC, 4,   0);
    add_req(32'd123456,   RADIX_DEC, 4,   0);    // keeps the low digits
    add_req(-32'sd42,     RADIX_DEC, 5,   0);
    add_req(32'd42,       RADIX_HEX, 5,   10);   // padding cut short
    add_req(32'd7,        RADIX_BIN, 64,  63);
    add_req(32'd0,        RADIX_HEX, 64,  63);
    add_req(-32'sd255,    RADIX_HEX, 65,  8);
    add_req(-32'sd2147483647, RADIX_OCT, 100, 0);
    add_req(32'hdead_beef, RADIX_HEX, 64,  0);
    add_req(32'h00ab_cdef, RADIX_HEX, 12,  0);
    add_req(32'd1,        RADIX_DEC, 64,  1);
    add_req(32'hffff_ffff, RADIX_BIN, 6,   0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      r.radix_sel = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1, 2: r.value = $urandom();
        3, 4:    r.value = $urandom_range(0, 300);
        5:       r.value = 32'd0 - $urandom_range(0, 300);
        6:       r.value = 32'h8000_0000 + $urandom_range(0, 3);
        7:       r.value = 32'h7fff_ffff - $urandom_range(0, 3);
        8:       r.value = 32'd1 << $urandom_range(0, 31);
        default: r.value = $urandom() & $urandom();
      endcase
      case ($urandom_range(0, 19))
        0:       r.buffer_len = LEN_W'($urandom_range(0, 3));
        1:       r.buffer_len = LEN_W'($urandom_range(65, 127));
        2, 3:    r.buffer_len = LEN_W'($urandom_range(4, 7));
        default: r.buffer_len = LEN_W'($urandom_range(4, 64));
      endcase
      case ($urandom_range(0, 9))
        0:       r.pad_width = PAD_W'($urandom_range(0, 63));
        1, 2:    r.pad_width = '0;
        default: r.pad_width = PAD_W'($urandom_range(0, 12));
      endcase
      pending_reqs.push_back(r);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d with too short a buffer), %0d bytes checked",
             reqs_taken, short_buf_reqs, bytes_checked);
    $display("radix mix bin/oct/dec/hex: %0d/%0d/%0d/%0d",
             radix_count[RADIX_BIN], radix_count[RADIX_OCT],
             radix_count[RADIX_DEC], radix_count[RADIX_HEX]);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (expected_bytes.size() != 0) begin
        $error("%0d expected bytes never arrived", expected_bytes.size());
      end
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
